[src/plom_pkg.sv]
// Package for the price level order matcher: shared types and codes.
// No dependencies.
`default_nettype none
package plom_pkg;

  typedef enum logic [1:0] {
    KIND_MKT_BUY  = 2'd0,
    KIND_MKT_SELL = 2'd1,
    KIND_LMT_BUY  = 2'd2,
    KIND_LMT_SELL = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_REST,
    ST_CLEAR
  } state_t;

endpackage
`default_nettype wire

[src/plom_front.sv]
// Front end of the order matcher: a small order queue that decodes each order.
// Depends on plom_pkg.
`default_nettype none
module plom_front #(
  parameter int PRICE_LEVELS = 64
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         push,
  output logic              full,
  input  wire logic [1:0]   kind,
  input  wire logic [5:0]   price,
  input  wire logic [19:0]  quantity,
  output logic              ord_valid,
  input  wire logic         ord_take,
  output logic              ord_buy,
  output logic              ord_limit,
  output logic [5:0]        ord_price,
  output logic [19:0]       ord_qty
);

  logic [1:0]  count;
  logic        wr_ptr;
  logic        rd_ptr;
  logic        q_buy   [2];
  logic        q_limit [2];
  logic [5:0]  q_price [2];
  logic [19:0] q_qty   [2];
  logic [5:0]  px_sat;
  logic        do_push;
  logic        do_pop;

  // Limit prices beyond the book clamp to the top level.
  assign px_sat = (32'(price) >= PRICE_LEVELS) ? 6'(PRICE_LEVELS - 1) : price;
  assign full = (count == 2'd2);
  assign do_push = push && !full;
  assign do_pop = ord_take && ord_valid;
  assign ord_valid = (count != 2'd0);
  assign ord_buy = q_buy[rd_ptr];
  assign ord_limit = q_limit[rd_ptr];
  assign ord_price = q_price[rd_ptr];
  assign ord_qty = q_qty[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
    end else begin
      if (do_push) wr_ptr <= ~wr_ptr;
      if (do_pop) rd_ptr <= ~rd_ptr;
      count <= count + 2'(do_push) - 2'(do_pop);
    end
    if (do_push) begin
      q_buy[wr_ptr] <= (kind == plom_pkg::KIND_MKT_BUY) || (kind == plom_pkg::KIND_LMT_BUY);
      q_limit[wr_ptr] <= (kind == plom_pkg::KIND_LMT_BUY) ||
                         (kind == plom_pkg::KIND_LMT_SELL);
      q_price[wr_ptr] <= px_sat;
      q_qty[wr_ptr] <= quantity;
    end
  end

endmodule
`default_nettype wire

[src/plom_back.sv]
// Back end of the order matcher: book memories, level walk and result register.
// Depends on plom_pkg.
`default_nettype none
module plom_back #(
  parameter int PRICE_LEVELS   = 64,
  parameter int LEVEL_QTY_BITS = 24
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         ord_valid,
  output logic              ord_take,
  input  wire logic         ord_buy,
  input  wire logic         ord_limit,
  input  wire logic [5:0]   ord_price,
  input  wire logic [19:0]  ord_qty,
  output logic              empty,
  input  wire logic         pop,
  output logic [5:0]        fill_price,
  output logic [19:0]       fill_qty,
  output logic [19:0]       left_qty,
  output logic              rested,
  output logic              last
);

  localparam int LW = (PRICE_LEVELS > 1) ? $clog2(PRICE_LEVELS) : 1;
  localparam int SW = ((LEVEL_QTY_BITS > 20) ? LEVEL_QTY_BITS : 20) + 1;
  localparam logic [LEVEL_QTY_BITS-1:0] LVL_MAX = '1;
  localparam logic [LW-1:0] TOP = LW'(PRICE_LEVELS - 1);

  // Book memories, one read port each with registered read data.
  logic [LEVEL_QTY_BITS-1:0] bid_mem [PRICE_LEVELS];
  logic [LEVEL_QTY_BITS-1:0] ask_mem [PRICE_LEVELS];
  logic [LEVEL_QTY_BITS-1:0] bid_rd, ask_rd;
  logic [LW-1:0] bid_addr, ask_addr;
  logic          bid_we, ask_we;
  logic [LW-1:0] bid_wa, ask_wa;
  logic [LEVEL_QTY_BITS-1:0] bid_wd, ask_wd;

  plom_pkg::state_t state, state_next;
  logic [LW-1:0] clr;
  logic [LW-1:0] lv, lv_next;
  logic [19:0]   rem;
  logic          buy, lim;
  logic [LW-1:0] px;
  logic [19:0]   orig;

  // Latest walk result, passed on once the next take or the end is known.
  logic          h_valid;
  logic [5:0]    h_price;
  logic [19:0]   h_fill, h_left;

  logic [LEVEL_QTY_BITS-1:0] avail;
  logic [LEVEL_QTY_BITS-1:0] own_q;
  logic [LEVEL_QTY_BITS-1:0] opp_wd;
  logic          crosses, at_end, take_lvl, room, adv, rest_now;
  logic [19:0]   take;
  logic [19:0]   rem_after;
  logic [SW-1:0] rest_sum;
  logic [LEVEL_QTY_BITS-1:0] rest_q;
  logic          cur_buy;
  logic [LW-1:0] cur_px, walk_addr;

  // Single-entry result register.
  logic          r_valid;
  logic          emit;
  logic [5:0]    e_price;
  logic [19:0]   e_fill, e_left;
  logic          e_rested, e_last;

  assign avail = buy ? ask_rd : bid_rd;
  assign own_q = buy ? bid_rd : ask_rd;
  assign crosses = !lim || (buy ? (lv <= px) : (lv >= px));
  assign at_end = buy ? (lv == TOP) : (lv == '0);
  assign take = (32'(avail) < 32'(rem)) ? 20'(avail) : rem;
  assign rem_after = rem - take;
  assign take_lvl = (rem != '0) && (avail != '0) && crosses;
  assign room = !r_valid || pop;
  assign adv = !h_valid || room;
  assign opp_wd = avail - LEVEL_QTY_BITS'(take);
  assign rest_sum = SW'(own_q) + SW'(rem);
  assign rest_q = (rest_sum > SW'(LVL_MAX)) ? LVL_MAX : rest_sum[LEVEL_QTY_BITS-1:0];
  assign rest_now = (state == plom_pkg::ST_REST) && room && lim && (rem != '0);

  assign empty = !r_valid;
  assign ord_take = (state == plom_pkg::ST_IDLE);

  // The opposite side is read at the level the walk looks at next; the own
  // side is always read at the order's price for the final resting step.
  assign cur_buy = (state == plom_pkg::ST_IDLE) ? ord_buy : buy;
  assign cur_px = (state == plom_pkg::ST_IDLE) ? LW'(ord_price) : px;
  assign walk_addr = (state == plom_pkg::ST_IDLE) ? (ord_buy ? '0 : TOP) : lv_next;
  assign bid_addr = cur_buy ? cur_px : walk_addr;
  assign ask_addr = cur_buy ? walk_addr : cur_px;

  always_comb begin
    lv_next = lv;
    if (state == plom_pkg::ST_WALK && !at_end && (!take_lvl || adv)) begin
      lv_next = buy ? lv + 1'b1 : lv - 1'b1;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      plom_pkg::ST_CLEAR: if (clr == TOP) state_next = plom_pkg::ST_IDLE;
      plom_pkg::ST_IDLE: if (ord_valid) state_next = plom_pkg::ST_WALK;
      plom_pkg::ST_WALK: begin
        if (rem == '0 || (avail != '0 && !crosses)) begin
          state_next = plom_pkg::ST_REST;
        end else if (take_lvl) begin
          if (adv && (rem_after == '0 || at_end)) state_next = plom_pkg::ST_REST;
        end else if (at_end) begin
          state_next = plom_pkg::ST_REST;
        end
      end
      plom_pkg::ST_REST: if (room) state_next = plom_pkg::ST_IDLE;
      default: state_next = plom_pkg::ST_IDLE;
    endcase
  end

  // A take sends the held result on, so it needs room only when one is held.
  // The final result is the held one, or a nothing-matched marker.
  always_comb begin
    emit = 1'b0;
    e_price = h_price;
    e_fill = h_fill;
    e_left = h_left;
    e_rested = 1'b0;
    e_last = 1'b0;
    case (state)
      plom_pkg::ST_WALK: emit = take_lvl && h_valid && room;
      plom_pkg::ST_REST: begin
        emit = room;
        e_rested = lim && (rem != '0);
        e_last = 1'b1;
        if (!h_valid) begin
          e_price = lim ? 6'(px) : 6'd0;
          e_fill = '0;
          e_left = orig;
        end
      end
      default: emit = 1'b0;
    endcase
  end

  always_comb begin
    bid_we = 1'b0;
    ask_we = 1'b0;
    bid_wa = lv;
    ask_wa = lv;
    bid_wd = opp_wd;
    ask_wd = opp_wd;
    case (state)
      plom_pkg::ST_CLEAR: begin
        bid_we = 1'b1;
        ask_we = 1'b1;
        bid_wa = clr;
        ask_wa = clr;
        bid_wd = '0;
        ask_wd = '0;
      end
      plom_pkg::ST_WALK: if (take_lvl && adv) begin
        if (buy) ask_we = 1'b1;
        else bid_we = 1'b1;
      end
      plom_pkg::ST_REST: if (rest_now) begin
        if (buy) begin
          bid_we = 1'b1;
          bid_wa = px;
          bid_wd = rest_q;
        end else begin
          ask_we = 1'b1;
          ask_wa = px;
          ask_wd = rest_q;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (bid_we) bid_mem[bid_wa] <= bid_wd;
    if (ask_we) ask_mem[ask_wa] <= ask_wd;
    bid_rd <= bid_mem[bid_addr];
    ask_rd <= ask_mem[ask_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= plom_pkg::ST_CLEAR;
      clr <= '0;
      r_valid <= 1'b0;
      h_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == plom_pkg::ST_CLEAR) clr <= clr + 1'b1;
      if (emit) r_valid <= 1'b1;
      else if (pop) r_valid <= 1'b0;
      case (state)
        plom_pkg::ST_IDLE: if (ord_valid) begin
          buy <= ord_buy;
          lim <= ord_limit;
          px <= LW'(ord_price);
          rem <= ord_qty;
          orig <= ord_qty;
          h_valid <= 1'b0;
          lv <= ord_buy ? '0 : TOP;
        end
        plom_pkg::ST_WALK: begin
          lv <= lv_next;
          if (take_lvl && adv) begin
            rem <= rem_after;
            h_valid <= 1'b1;
            h_price <= 6'(lv);
            h_fill <= take;
            h_left <= rem_after;
          end
        end
        default: ;
      endcase
    end
    if (emit) begin
      fill_price <= e_price;
      fill_qty <= e_fill;
      left_qty <= e_left;
      rested <= e_rested;
      last <= e_last;
    end
  end

endmodule
`default_nettype wire

[src/price_level_order_matcher.sv]
// Top level of the price level order matcher.
// Depends on plom_pkg, plom_front and plom_back.
//
// Usage: orders enter through a queue-like port (push/full) carrying kind,
// price and quantity. Results leave through a queue-like port (empty/pop):
// the oldest result sits on fill_price, fill_qty, left_qty, rested and last
// while empty is low, and a transfer happens when pop is high.
// A front queue of two orders decodes each order and clamps its price; the
// back end walks the opposite side of the book one price level per cycle
// while not stalled, starting at the best level, and emits one result per
// level consumed, or one nothing-matched result. Each take is held back
// until the next take or the end is known, so the final result can carry
// last. An order passes through a start step, a walk step per level visited
// and a finishing step; the back end takes no new order until that is done.
// The book lives in two memories. After rst the back end clears them level
// by level before it takes an order; the front queue still takes two orders
// meanwhile, and the result register comes out of reset empty.
// When the receiver stalls, the single result register holds its entry, the
// walk pauses at a take while an earlier take is held and the finishing step
// waits; orders keep queuing until full.
`default_nettype none
module price_level_order_matcher #(
  parameter int PRICE_LEVELS   = 64,
  parameter int LEVEL_QTY_BITS = 24
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        push,
  output logic             full,
  input  wire logic [1:0]  kind,
  input  wire logic [5:0]  price,
  input  wire logic [19:0] quantity,
  output logic             empty,
  input  wire logic        pop,
  output logic [5:0]       fill_price,
  output logic [19:0]      fill_qty,
  output logic [19:0]      left_qty,
  output logic             rested,
  output logic             last
);

  logic        ord_valid, ord_take, ord_buy, ord_limit;
  logic [5:0]  ord_price;
  logic [19:0] ord_qty;

  plom_front #(.PRICE_LEVELS(PRICE_LEVELS)) u_front (
    .clk, .rst, .push, .full, .kind, .price, .quantity,
    .ord_valid, .ord_take, .ord_buy, .ord_limit, .ord_price, .ord_qty
  );

  plom_back #(.PRICE_LEVELS(PRICE_LEVELS), .LEVEL_QTY_BITS(LEVEL_QTY_BITS)) u_back (
    .clk, .rst, .ord_valid, .ord_take, .ord_buy, .ord_limit, .ord_price, .ord_qty,
    .empty, .pop, .fill_price, .fill_qty, .left_qty, .rested, .last
  );

  // Only the final result may report resting, every earlier result fills
  // something, and a waiting result holds still.
  a_rested_last: assert property (@(posedge clk) disable iff (rst)
    (!empty && rested) |-> last) else $error("rested without last");
  a_fill_nonzero: assert property (@(posedge clk) disable iff (rst)
    (!empty && !last) |-> (fill_qty != 20'd0)) else $error("empty fill mid-order");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(fill_qty) && $stable(fill_price)))
    else $error("result changed while stalled");

endmodule
`default_nettype wire
